// ===== sv/cpr_pkg.sv =====
`default_nettype none

package cpr_pkg;

  localparam int unsigned FRAMES_DEF    = 16;
  localparam int unsigned PAGE_BITS_DEF = 16;

  // Fixed field widths of the channels and the frame count register
  localparam int unsigned PAGE_W  = 16;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CFG_W   = 5;

  localparam logic [CFG_W-1:0]   FRAMES_RST = CFG_W'(16);
  localparam logic [COUNT_W-1:0] FAULT_MAX  = '1;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [0:0] {
    BK_IDLE,
    BK_SWEEP
  } bk_state_e;

  function automatic int unsigned idx_width(input int unsigned frames);
    return (frames > 1) ? $clog2(frames) : 1;
  endfunction

  function automatic int unsigned store_width(input int unsigned page_bits);
    return (page_bits < PAGE_W) ? page_bits : PAGE_W;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cpr_chan_if.sv =====
`default_nettype none

interface cpr_page_if;
  logic                        valid;
  logic                        ready;
  logic [cpr_pkg::PAGE_W-1:0]  page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

interface cpr_result_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [cpr_pkg::SLOT_W-1:0]  slot;
  logic [cpr_pkg::COUNT_W-1:0] fault_count;

  modport source (output valid, output hit, output slot, output fault_count, input ready);
  modport sink   (input valid, input hit, input slot, input fault_count, output ready);
endinterface

`default_nettype wire

// ===== sv/cpr_queue.sv =====
`default_nettype none

module cpr_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = cpr_pkg::QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] pop_data_o,
  output logic         empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;

  assign full_o     = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (AW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cpr_front.sv =====
`default_nettype none

module cpr_front #(
  parameter int unsigned FRAMES    = cpr_pkg::FRAMES_DEF,
  parameter int unsigned PAGE_BITS = cpr_pkg::PAGE_BITS_DEF,
  localparam int unsigned IW = cpr_pkg::idx_width(FRAMES),
  localparam int unsigned SW = cpr_pkg::store_width(PAGE_BITS),
  localparam int unsigned QW = 1 + IW + SW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clear_i,
  cpr_page_if.sink      page_i,
  output logic          push_o,
  output logic [QW-1:0] push_data_o,
  input  logic          full_i,
  input  logic          fill_we_i,
  input  logic [IW-1:0] fill_idx_i,
  input  logic [SW-1:0] fill_page_i
);

  logic              s_valid_q, s_valid_d;
  logic [SW-1:0]     s_page_q;
  logic [SW-1:0]     page_store_q [FRAMES];
  logic [FRAMES-1:0] valid_q;
  logic              miss_pend_q;
  logic [FRAMES-1:0] match;
  logic              hit;
  logic [IW-1:0]     hit_idx;
  logic              accept;

  // Resident pages are unique, so the match vector is one-hot or empty
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < FRAMES; i++) begin
      match[i] = valid_q[i] && (page_store_q[i] == s_page_q);
      if (match[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  assign hit = |match;

  // Hold the next word while a fill is still to come: it may hit the new page
  assign push_o       = s_valid_q && !full_i && !miss_pend_q;
  assign push_data_o  = {hit, hit_idx, s_page_q};
  assign page_i.ready = !s_valid_q || push_o;
  assign accept       = page_i.valid && page_i.ready;

  always_comb begin
    s_valid_d = s_valid_q;
    if (accept) begin
      s_valid_d = 1'b1;
    end else if (push_o) begin
      s_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q   <= 1'b0;
      valid_q     <= '0;
      miss_pend_q <= 1'b0;
    end else begin
      s_valid_q <= s_valid_d;
      if (clear_i) begin
        valid_q     <= '0;
        miss_pend_q <= 1'b0;
      end else begin
        if (fill_we_i) begin
          valid_q[fill_idx_i] <= 1'b1;
          miss_pend_q         <= 1'b0;
        end else if (push_o && !hit) begin
          miss_pend_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_page_q <= SW'(page_i.page);
    end
    if (fill_we_i) begin
      page_store_q[fill_idx_i] <= fill_page_i;
    end
  end

  a_unique_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_q |-> $onehot0(match))
    else $error("page resident in more than one frame");

  a_fill_expected : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_we_i |-> miss_pend_q)
    else $error("frame filled with no miss in flight");

endmodule

`default_nettype wire

// ===== sv/cpr_back.sv =====
`default_nettype none

module cpr_back #(
  parameter int unsigned FRAMES    = cpr_pkg::FRAMES_DEF,
  parameter int unsigned PAGE_BITS = cpr_pkg::PAGE_BITS_DEF,
  localparam int unsigned IW = cpr_pkg::idx_width(FRAMES),
  localparam int unsigned SW = cpr_pkg::store_width(PAGE_BITS),
  localparam int unsigned NW = IW + 1,
  localparam int unsigned QW = 1 + IW + SW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clear_i,
  input  logic [NW-1:0] n_act_i,
  output logic          pop_o,
  input  logic [QW-1:0] pop_data_i,
  input  logic          empty_i,
  output logic          fill_we_o,
  output logic [IW-1:0] fill_idx_o,
  output logic [SW-1:0] fill_page_o,
  cpr_result_if.source  result_o
);

  cpr_pkg::bk_state_e state_q, state_d;

  logic [FRAMES-1:0]           marks_q, marks_d;
  logic [IW-1:0]               hand_q, hand_d, hand_next;
  logic [cpr_pkg::COUNT_W-1:0] fault_q, fault_d, fault_inc;
  logic [SW-1:0]               work_page_q;
  logic                        out_valid_q, out_hit_q;
  logic [cpr_pkg::SLOT_W-1:0]  out_slot_q;
  logic [cpr_pkg::COUNT_W-1:0] out_fault_q;

  logic                        out_free;
  logic                        q_hit;
  logic [IW-1:0]               q_idx;
  logic [SW-1:0]               q_page;
  logic                        load_page;
  logic                        load_out;
  logic                        ld_hit;
  logic [IW-1:0]               ld_idx;
  logic [cpr_pkg::COUNT_W-1:0] ld_fault;

  assign {q_hit, q_idx, q_page} = pop_data_i;
  assign out_free  = !out_valid_q || result_o.ready;
  assign hand_next = ((NW'(hand_q) + NW'(1)) == n_act_i) ? '0 : hand_q + IW'(1);
  assign fault_inc = (fault_q == cpr_pkg::FAULT_MAX) ? fault_q
                                                     : fault_q + cpr_pkg::COUNT_W'(1);

  always_comb begin
    state_d   = state_q;
    marks_d   = marks_q;
    hand_d    = hand_q;
    fault_d   = fault_q;
    pop_o     = 1'b0;
    fill_we_o = 1'b0;
    load_page = 1'b0;
    load_out  = 1'b0;
    ld_hit    = 1'b0;
    ld_idx    = hand_q;
    ld_fault  = fault_q;
    unique case (state_q)
      cpr_pkg::BK_IDLE: begin
        // A hit needs the output register; a miss only starts the sweep
        if (!empty_i && (out_free || !q_hit)) begin
          pop_o = 1'b1;
          if (q_hit) begin
            marks_d[q_idx] = 1'b1;
            load_out       = 1'b1;
            ld_hit         = 1'b1;
            ld_idx         = q_idx;
          end else begin
            load_page = 1'b1;
            state_d   = cpr_pkg::BK_SWEEP;
          end
        end
      end
      cpr_pkg::BK_SWEEP: begin
        if (marks_q[hand_q]) begin
          // second chance: drop the mark and pass over
          marks_d[hand_q] = 1'b0;
          hand_d          = hand_next;
        end else if (out_free) begin
          fill_we_o = 1'b1;
          hand_d    = hand_next;
          fault_d   = fault_inc;
          load_out  = 1'b1;
          ld_fault  = fault_inc;
          state_d   = cpr_pkg::BK_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpr_pkg::BK_IDLE;
      marks_q     <= '0;
      hand_q      <= '0;
      fault_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (clear_i) begin
        state_q <= cpr_pkg::BK_IDLE;
        marks_q <= '0;
        hand_q  <= '0;
        fault_q <= '0;
      end else begin
        state_q <= state_d;
        marks_q <= marks_d;
        hand_q  <= hand_d;
        fault_q <= fault_d;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_page) begin
      work_page_q <= q_page;
    end
    if (load_out) begin
      out_hit_q   <= ld_hit;
      out_slot_q  <= cpr_pkg::SLOT_W'(ld_idx);
      out_fault_q <= ld_fault;
    end
  end

  assign fill_idx_o           = hand_q;
  assign fill_page_o          = work_page_q;
  assign result_o.valid       = out_valid_q;
  assign result_o.hit         = out_hit_q;
  assign result_o.slot        = out_slot_q;
  assign result_o.fault_count = out_fault_q;

  a_hand_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    NW'(hand_q) < n_act_i)
    else $error("clock hand outside managed frames");

  a_fault_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clear_i |=> fault_q >= $past(fault_q))
    else $error("fault count fell without a clear");

  a_fill_reports_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_we_o |=> out_valid_q && !out_hit_q)
    else $error("fill not followed by a miss word");

endmodule

`default_nettype wire

// ===== sv/clock_page_replacement.sv =====
`default_nettype none

// Clock (second-chance) page replacement over FRAMES frames, of which the
// frames_in_use register manages the first 1..FRAMES (0 acts as 1, larger
// values as FRAMES); any write to it empties the table and zeroes the marks,
// the hand and the fault count, and must only be made while the block is
// idle. Each page word gives one result word: hit or miss, the frame hit or
// filled, and the saturating fault count. The front end registers the word,
// matches it against all resident pages at once and queues it; hits stream
// at one word per cycle while the receiver takes results, passing through
// the input register, the queue and the result register. On a miss the
// back end sweeps, testing one frame per cycle and clearing each set mark
// the hand passes (at most the number of managed frames), then fills the
// first unmarked frame when the result register is free; the front end holds
// the next word until that fill is done. A new result loads as the last is taken.
module clock_page_replacement #(
  parameter int unsigned FRAMES    = cpr_pkg::FRAMES_DEF,
  parameter int unsigned PAGE_BITS = cpr_pkg::PAGE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      frames_in_use_we_i,
  input  logic [cpr_pkg::CFG_W-1:0] frames_in_use_i,
  cpr_page_if.sink                  page_i,
  cpr_result_if.source              result_o
);

  localparam int unsigned IW = cpr_pkg::idx_width(FRAMES);
  localparam int unsigned SW = cpr_pkg::store_width(PAGE_BITS);
  localparam int unsigned NW = IW + 1;
  localparam int unsigned QW = 1 + IW + SW;

  logic [cpr_pkg::CFG_W-1:0] frames_q;
  logic [NW-1:0]             n_act;
  logic                      push;
  logic [QW-1:0]             push_data;
  logic                      full;
  logic                      pop;
  logic [QW-1:0]             pop_data;
  logic                      empty;
  logic                      fill_we;
  logic [IW-1:0]             fill_idx;
  logic [SW-1:0]             fill_page;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= cpr_pkg::FRAMES_RST;
    end else if (frames_in_use_we_i) begin
      frames_q <= frames_in_use_i;
    end
  end

  always_comb begin
    if (frames_q == '0) begin
      n_act = NW'(1);
    end else if (32'(frames_q) > 32'(FRAMES)) begin
      n_act = NW'(FRAMES);
    end else begin
      n_act = NW'(frames_q);
    end
  end

  cpr_front #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (frames_in_use_we_i),
    .page_i      (page_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full),
    .fill_we_i   (fill_we),
    .fill_idx_i  (fill_idx),
    .fill_page_i (fill_page)
  );

  cpr_queue #(
    .W     (QW),
    .DEPTH (cpr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  cpr_back #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (frames_in_use_we_i),
    .n_act_i     (n_act),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .empty_i     (empty),
    .fill_we_o   (fill_we),
    .fill_idx_o  (fill_idx),
    .fill_page_o (fill_page),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned FRAMES_DEF = cpr_pkg::FRAMES_DEF;
  localparam int unsigned PAGE_W     = cpr_pkg::PAGE_W;
  localparam int unsigned SLOT_W     = cpr_pkg::SLOT_W;
  localparam int unsigned COUNT_W    = cpr_pkg::COUNT_W;
  localparam int unsigned CFG_W      = cpr_pkg::CFG_W;

  localparam int unsigned DRAIN_CYCLES  = FRAMES_DEF + 8;
  localparam int unsigned BURST_WORDS   = 125;
  localparam int unsigned POOL_EXTRA    = 3;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] fault_count;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic frames_we;
  logic [CFG_W-1:0] frames_data;

  cpr_page_if   page_if ();
  cpr_result_if result_if ();

  clock_page_replacement u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .frames_in_use_we_i (frames_we),
    .frames_in_use_i    (frames_data),
    .page_i             (page_if),
    .result_o           (result_if)
  );

  // Shadow of the frame table
  logic [CFG_W-1:0]   frames_cfg;
  logic [PAGE_W-1:0]  resident_page [FRAMES_DEF];
  bit                 frame_full    [FRAMES_DEF];
  bit                 ref_mark      [FRAMES_DEF];
  int unsigned        hand_pos;
  logic [COUNT_W-1:0] fault_total;

  outcome_t outcome_q [$];
  int unsigned err_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned managed_frames(input logic [CFG_W-1:0] cfg);
    if (cfg == 0) return 1;
    if (cfg > FRAMES_DEF) return FRAMES_DEF;
    return 32'(cfg);
  endfunction

  function automatic void clear_frames();
    for (int i = 0; i < FRAMES_DEF; i++) begin
      frame_full[i] = 1'b0;
      ref_mark[i]   = 1'b0;
    end
    hand_pos    = 0;
    fault_total = '0;
  endfunction

  function automatic outcome_t clock_lookup(input logic [PAGE_W-1:0] pg);
    int unsigned n;
    int unsigned h;
    outcome_t res;
    n = managed_frames(frames_cfg);
    for (int i = 0; i < n; i++) begin
      if (frame_full[i] && resident_page[i] == pg) begin
        ref_mark[i]     = 1'b1;
        res.hit         = 1'b1;
        res.slot        = SLOT_W'(i);
        res.fault_count = fault_total;
        return res;
      end
    end
    // Give each marked frame its second chance: clear and pass over
    h = hand_pos % n;
    for (int s = 0; s < 2 * n; s++) begin
      if (!ref_mark[h]) break;
      ref_mark[h] = 1'b0;
      h = (h + 1) % n;
    end
    resident_page[h] = pg;
    frame_full[h]    = 1'b1;
    ref_mark[h]      = 1'b0;
    hand_pos         = (h + 1) % n;
    if (fault_total != cpr_pkg::FAULT_MAX) fault_total = fault_total + 1'b1;
    res.hit         = 1'b0;
    res.slot        = SLOT_W'(h);
    res.fault_count = fault_total;
    return res;
  endfunction

  // Receiver back-pressure
  always @(negedge clk_i) begin
    result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (outcome_q.size() == 0) begin
        $error("result word with nothing outstanding: hit %0d slot %0d fault_count %0d",
               result_if.hit, result_if.slot, result_if.fault_count);
        err_count++;
      end else begin
        want = outcome_q.pop_front();
        if (result_if.hit !== want.hit) begin
          $error("hit: expected %0d, actual %0d", want.hit, result_if.hit);
          err_count++;
        end
        if (result_if.slot !== want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot, result_if.slot);
          err_count++;
        end
        if (result_if.fault_count !== want.fault_count) begin
          $error("fault_count: expected %0d, actual %0d",
                 want.fault_count, result_if.fault_count);
          err_count++;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_page(input logic [PAGE_W-1:0] pg);
    while ($urandom_range(99) < send_idle_pct) begin
      page_if.valid = 1'b0;
      @(negedge clk_i);
    end
    page_if.valid = 1'b1;
    page_if.page  = pg;
    do @(posedge clk_i); while (!page_if.ready);
    outcome_q.insert(outcome_q.size(), clock_lookup(pg));
    @(negedge clk_i);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] value);
    page_if.valid = 1'b0;
    while (outcome_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    frames_we   = 1'b1;
    frames_data = value;
    @(negedge clk_i);
    frames_we  = 1'b0;
    frames_cfg = value;
    clear_frames();
  endtask

  task automatic test_reset_default();
    logic [PAGE_W-1:0] words [6] = '{16'h0042, 16'h0043, 16'h0042, 16'hBEEF,
                                     16'h0043, 16'h0044};
    foreach (words[i]) send_page(words[i]);
  endtask

  task automatic test_directed();
    // Fill four frames, mark two, evict past them, then force a full pass
    logic [PAGE_W-1:0] four [13] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                     16'hFFFF, 16'h0000, 16'h1234, 16'h5555,
                                     16'h0000, 16'h1234, 16'h5555, 16'hFFFF,
                                     16'hAAAA};
    write_frames(CFG_W'(4));
    foreach (four[i]) send_page(four[i]);
    // Single frame: a marked frame is still the only victim
    write_frames(CFG_W'(1));
    send_page(16'h7FFF);
    send_page(16'h7FFF);
    send_page(16'h0002);
    // Zero acts as one frame
    write_frames(CFG_W'(0));
    send_page(16'h00FF);
    send_page(16'h00FF);
    send_page(16'hFF00);
    // Above the table size acts as the full table
    write_frames(CFG_W'(31));
    send_page(16'h3C3C);
    send_page(16'hC3C3);
    send_page(16'h3C3C);
  endtask

  task automatic random_burst(input logic [CFG_W-1:0] cfg, input int unsigned idle_pct,
                              input int unsigned stall_pct);
    logic [PAGE_W-1:0] pool [FRAMES_DEF + POOL_EXTRA];
    int unsigned pool_size;
    write_frames(cfg);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    // Working set slightly larger than the table keeps hits and misses mixed
    pool_size = managed_frames(cfg) + POOL_EXTRA;
    for (int i = 0; i < pool_size; i++) pool[i] = PAGE_W'($urandom_range(65535));
    repeat (BURST_WORDS) begin
      if ($urandom_range(99) < 85) send_page(pool[$urandom_range(pool_size - 1)]);
      else send_page(PAGE_W'($urandom_range(65535)));
    end
  endtask

  task automatic test_random();
    int unsigned idle_tab  [4] = '{0, 84, 0, 7};
    int unsigned stall_tab [4] = '{0, 0, 84, 7};
    logic [CFG_W-1:0] cfg_tab [8];
    cfg_tab = '{CFG_W'(16), CFG_W'(1), CFG_W'(0), CFG_W'(31),
                CFG_W'($urandom_range(15, 2)), CFG_W'(8),
                CFG_W'($urandom_range(30, 17)), CFG_W'(5)};
    foreach (cfg_tab[i]) random_burst(cfg_tab[i], idle_tab[i % 4], stall_tab[i % 4]);
  endtask

  initial begin
    rst_ni        = 1'b0;
    frames_we     = 1'b0;
    frames_data   = cpr_pkg::FRAMES_RST;
    page_if.valid = 1'b0;
    page_if.page  = '0;
    frames_cfg    = cpr_pkg::FRAMES_RST;
    clear_frames();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_default();
    test_directed();
    test_random();

    page_if.valid = 1'b0;
    recv_stall_pct = 7;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS clock_page_replacement");
    end else begin
      $display("FAIL clock_page_replacement");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL clock_page_replacement");
    $finish;
  end

endmodule

// ===== files.f =====
sv/cpr_pkg.sv
sv/cpr_chan_if.sv
sv/cpr_queue.sv
sv/cpr_front.sv
sv/cpr_back.sv
sv/clock_page_replacement.sv
verif/tb_top.sv
